FILE: hdl/sbest_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the spectral bin envelope state tracker.
package sbest_pkg;

  // Width of the bin index field on both channels.
  localparam int BIN_W = 10;

  // Envelope state codes.
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_NULL     = 3'd0;
  localparam logic [ST_W-1:0] ST_ATTACK   = 3'd1;
  localparam logic [ST_W-1:0] ST_INCREASE = 3'd2;
  localparam logic [ST_W-1:0] ST_SUSTAIN  = 3'd3;
  localparam logic [ST_W-1:0] ST_DECREASE = 3'd4;

  // Configuration port.
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam int THR_W  = 16;

  localparam logic [1:0] REG_SUSTAIN_MIN = 2'd0;
  localparam logic [1:0] REG_SUSTAIN_MAX = 2'd1;
  localparam logic [1:0] REG_ATTACK_MIN  = 2'd2;

  localparam logic [THR_W-1:0] SUSTAIN_MIN_RST = 16'hFFF3;
  localparam logic [THR_W-1:0] SUSTAIN_MAX_RST = 16'h000D;
  localparam logic [THR_W-1:0] ATTACK_MIN_RST  = 16'h0080;

endpackage

FILE: hdl/sbest_if.sv
`timescale 1ns / 1ps
// Request and result channel interfaces of the envelope state tracker.
interface sbest_in_if #(
  parameter int AMP_BITS = 24
);
  logic                        valid;
  logic                        ready;
  logic [sbest_pkg::BIN_W-1:0] bin_index;
  logic [AMP_BITS-1:0]         amplitude;
  logic                        below_hearing_threshold;
  logic                        start_of_series;

  modport source (
    output valid, bin_index, amplitude, below_hearing_threshold, start_of_series,
    input  ready
  );
  modport sink (
    input  valid, bin_index, amplitude, below_hearing_threshold, start_of_series,
    output ready
  );
endinterface

interface sbest_out_if #(
  parameter int AMP_BITS   = 24,
  parameter int COUNT_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic [sbest_pkg::BIN_W-1:0] out_bin_index;
  logic [sbest_pkg::ST_W-1:0]  envelope_state;
  logic                        is_transition;
  logic [COUNT_BITS-1:0]       state_run_frames;
  logic [COUNT_BITS-1:0]       active_run_frames;
  logic [AMP_BITS-1:0]         effective_amplitude;
  logic signed [AMP_BITS:0]    first_difference;

  modport source (
    output valid, out_bin_index, envelope_state, is_transition, state_run_frames,
           active_run_frames, effective_amplitude, first_difference,
    input  ready
  );
  modport sink (
    input  valid, out_bin_index, envelope_state, is_transition, state_run_frames,
           active_run_frames, effective_amplitude, first_difference,
    output ready
  );
endinterface

FILE: hdl/spectral_bin_envelope_state_tracker.sv
`timescale 1ns / 1ps
// Spectral bin envelope state tracker: per-bin envelope classification and run counters.
//
// Takes one request per clock while in_ch.ready is high (amplitude, bin index, masking
// and start flags) and returns one result per request in order. Per-bin history (last
// effective amplitude, last state, state-run and active-run counters) lives in a single
// NUM_BINS-deep synchronous RAM with a registered read. A request walks four stages:
// capture and reciprocal multiply for the bin modulo, index fix-up and RAM read, threshold
// products, then classify and write back. Back-to-back requests to the same bin are
// covered by forwarding from the stage ahead and from the last written entry, so the
// sustained rate is one request per cycle while credits remain; a result passes the
// stage registers and the result FIFO before it shows on out_ch. An 8-entry result FIFO
// with credit counting parts the two sides, so requests keep flowing while results wait
// until the credits run out. After reset the RAM is cleared by a pass over all NUM_BINS
// entries during which in_ch.ready stays low; configuration writes are taken at any time.
module spectral_bin_envelope_state_tracker #(
  parameter int NUM_BINS   = 1024,
  parameter int AMP_BITS   = 24,
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sbest_in_if.sink                      in_ch,
  sbest_out_if.source                   out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbest_pkg::APB_AW-1:0]  paddr,
  input  logic [sbest_pkg::APB_DW-1:0]  pwdata,
  output logic [sbest_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);

  localparam int BIN_W  = sbest_pkg::BIN_W;
  localparam int ST_W   = sbest_pkg::ST_W;
  localparam int THR_W  = sbest_pkg::THR_W;
  localparam int IDX_W  = $clog2(NUM_BINS);
  // bin modulo: q = (x * RECIP) >> RSH underestimates by at most one
  localparam int RSH    = 20;
  localparam int PRD_W  = 31;
  localparam int RECIP  = (1 << RSH) / NUM_BINS;
  localparam int QN_W   = BIN_W + 17;
  localparam int PW     = THR_W + AMP_BITS + 1;  // threshold * last
  localparam int DW     = AMP_BITS + 9;          // diff * 256
  localparam int FD     = 8;
  localparam int FA_W   = $clog2(FD);
  localparam int FC_W   = FA_W + 1;

  typedef struct packed {
    logic [AMP_BITS-1:0]   amp;
    logic [ST_W-1:0]       st;
    logic [COUNT_BITS-1:0] srun;
    logic [COUNT_BITS-1:0] arun;
  } ent_t;

  typedef struct packed {
    logic [BIN_W-1:0]         bin;
    logic [ST_W-1:0]          st;
    logic                     trans;
    logic [COUNT_BITS-1:0]    srun;
    logic [COUNT_BITS-1:0]    arun;
    logic [AMP_BITS-1:0]      eff;
    logic [AMP_BITS:0]        diff;
  } res_t;

  // ---------------------------------------------------------------- config registers
  logic [THR_W-1:0] sus_min_r, sus_max_r, att_min_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sus_min_r <= sbest_pkg::SUSTAIN_MIN_RST;
      sus_max_r <= sbest_pkg::SUSTAIN_MAX_RST;
      att_min_r <= sbest_pkg::ATTACK_MIN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        sbest_pkg::REG_SUSTAIN_MIN: sus_min_r <= pwdata[THR_W-1:0];
        sbest_pkg::REG_SUSTAIN_MAX: sus_max_r <= pwdata[THR_W-1:0];
        sbest_pkg::REG_ATTACK_MIN:  att_min_r <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      sbest_pkg::REG_SUSTAIN_MIN: prdata = {{(sbest_pkg::APB_DW-THR_W){1'b0}}, sus_min_r};
      sbest_pkg::REG_SUSTAIN_MAX: prdata = {{(sbest_pkg::APB_DW-THR_W){1'b0}}, sus_max_r};
      sbest_pkg::REG_ATTACK_MIN:  prdata = {{(sbest_pkg::APB_DW-THR_W){1'b0}}, att_min_r};
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- clearing pass
  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == IDX_W'(NUM_BINS - 1)) clr_busy_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- credit count
  // Credits cover every request in the pipe plus every result in the FIFO.
  logic [FC_W-1:0] cr_cnt_r, cr_cnt_nxt;
  logic            in_acc, out_acc;

  assign in_ch.ready = !clr_busy_r && (cr_cnt_r < FC_W'(FD));
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;

  always_comb begin
    cr_cnt_nxt = cr_cnt_r;
    if (in_acc && !out_acc) cr_cnt_nxt = cr_cnt_r + 1'b1;
    if (!in_acc && out_acc) cr_cnt_nxt = cr_cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cr_cnt_r <= '0;
    else        cr_cnt_r <= cr_cnt_nxt;
  end

  // ---------------------------------------------------------------- stage 1: capture
  logic                p1_v_r;
  logic [BIN_W-1:0]    p1_bin_r;
  logic [BIN_W-1:0]    p1_q_r;
  logic [AMP_BITS-1:0] p1_eff_r;
  logic                p1_start_r;
  logic [PRD_W-1:0]    q_prod;

  assign q_prod = PRD_W'(in_ch.bin_index) * PRD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) p1_v_r <= 1'b0;
    else        p1_v_r <= in_acc;
  end

  always_ff @(posedge clk) begin
    p1_bin_r   <= in_ch.bin_index;
    p1_q_r     <= q_prod[RSH +: BIN_W];
    p1_eff_r   <= in_ch.below_hearing_threshold ? '0 : in_ch.amplitude;
    p1_start_r <= in_ch.start_of_series;
  end

  // ---------------------------------------------------------------- stage 2: index, read
  logic [QN_W-1:0]  qn, rem0, rem1;
  logic [IDX_W-1:0] p1_idx;

  always_comb begin
    qn     = QN_W'(p1_q_r) * QN_W'(NUM_BINS);
    rem0   = QN_W'(p1_bin_r) - qn;
    rem1   = (rem0 >= QN_W'(NUM_BINS)) ? rem0 - QN_W'(NUM_BINS) : rem0;
    p1_idx = rem1[IDX_W-1:0];
  end

  ent_t mem [NUM_BINS];
  ent_t mem_rd_r;

  logic                p2_v_r;
  logic [BIN_W-1:0]    p2_bin_r;
  logic [IDX_W-1:0]    p2_idx_r;
  logic [AMP_BITS-1:0] p2_eff_r;
  logic                p2_start_r;

  always_ff @(posedge clk) begin
    mem_rd_r <= mem[p1_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p2_v_r <= 1'b0;
    else        p2_v_r <= p1_v_r;
  end

  always_ff @(posedge clk) begin
    p2_bin_r   <= p1_bin_r;
    p2_idx_r   <= p1_idx;
    p2_eff_r   <= p1_eff_r;
    p2_start_r <= p1_start_r;
  end

  // ---------------------------------------------------------------- stage 3: products
  logic                p3_v_r;
  logic [BIN_W-1:0]    p3_bin_r;
  logic [IDX_W-1:0]    p3_idx_r;
  logic [AMP_BITS-1:0] p3_eff_r;
  logic                p3_start_r;
  logic                p3_eff_zero_r, p3_last_zero_r;
  logic signed [AMP_BITS:0] p3_diff_r;
  logic signed [DW-1:0]     p3_d256_r;
  logic signed [PW-1:0]     p3_p0_r, p3_p1_r, p3_p2_r;
  ent_t                p3_prev_r;

  // last written entry, registered as it leaves stage 3
  logic                wb_v_r;
  logic [IDX_W-1:0]    wb_idx_r;
  ent_t                wb_ent_r;

  logic                hit_p3, hit_wb2;
  logic [AMP_BITS-1:0] last2;
  ent_t                prev2;
  logic signed [AMP_BITS:0] diff2;
  logic signed [PW-1:0]     p0, p1, p2;

  always_comb begin
    hit_p3  = p3_v_r && (p3_idx_r == p2_idx_r);
    hit_wb2 = wb_v_r && (wb_idx_r == p2_idx_r);
    prev2   = hit_wb2 ? wb_ent_r : mem_rd_r;
    if (p2_start_r)  last2 = '0;
    else if (hit_p3) last2 = p3_eff_r;
    else             last2 = prev2.amp;
    diff2 = $signed({1'b0, p2_eff_r}) - $signed({1'b0, last2});
    p0    = $signed(sus_min_r) * $signed({1'b0, last2});
    p1    = $signed(sus_max_r) * $signed({1'b0, last2});
    p2    = $signed(att_min_r) * $signed({1'b0, last2});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p3_v_r <= 1'b0;
    else        p3_v_r <= p2_v_r;
  end

  always_ff @(posedge clk) begin
    p3_bin_r       <= p2_bin_r;
    p3_idx_r       <= p2_idx_r;
    p3_eff_r       <= p2_eff_r;
    p3_start_r     <= p2_start_r;
    p3_eff_zero_r  <= (p2_eff_r == '0);
    p3_last_zero_r <= (last2 == '0);
    p3_diff_r      <= diff2;
    p3_d256_r      <= $signed({diff2, 8'd0});
    p3_p0_r        <= p0;
    p3_p1_r        <= p1;
    p3_p2_r        <= p2;
    p3_prev_r      <= prev2;
  end

  // ---------------------------------------------------------------- stage 4: classify, write
  logic                  hit_wb3;
  logic [ST_W-1:0]       pst, st;
  logic [COUNT_BITS-1:0] psrun, parun, srun_inc, arun_inc, srun_n, arun_n;
  logic                  trans;
  ent_t                  new_ent;
  res_t                  res;

  always_comb begin
    hit_wb3 = wb_v_r && (wb_idx_r == p3_idx_r);
    if (p3_start_r) begin
      pst   = sbest_pkg::ST_NULL;
      psrun = '0;
      parun = '0;
    end else if (hit_wb3) begin
      pst   = wb_ent_r.st;
      psrun = wb_ent_r.srun;
      parun = wb_ent_r.arun;
    end else begin
      pst   = p3_prev_r.st;
      psrun = p3_prev_r.srun;
      parun = p3_prev_r.arun;
    end

    if (p3_eff_zero_r)             st = sbest_pkg::ST_NULL;
    else if (p3_last_zero_r)       st = sbest_pkg::ST_ATTACK;
    else if (p3_d256_r < p3_p0_r)  st = sbest_pkg::ST_DECREASE;
    else if (p3_d256_r < p3_p1_r)  st = sbest_pkg::ST_SUSTAIN;
    else if (p3_d256_r < p3_p2_r)  st = sbest_pkg::ST_INCREASE;
    else                           st = sbest_pkg::ST_ATTACK;

    srun_inc = (psrun == '1) ? psrun : psrun + 1'b1;
    arun_inc = (parun == '1) ? parun : parun + 1'b1;
    trans    = 1'b0;
    if (st == sbest_pkg::ST_NULL) begin
      srun_n = '0;
      arun_n = '0;
    end else if (st == pst) begin
      srun_n = srun_inc;
      arun_n = arun_inc;
    end else begin
      trans  = 1'b1;
      srun_n = COUNT_BITS'(1);
      arun_n = (pst == sbest_pkg::ST_NULL) ? COUNT_BITS'(1) : arun_inc;
    end

    new_ent.amp  = p3_eff_r;
    new_ent.st   = st;
    new_ent.srun = srun_n;
    new_ent.arun = arun_n;

    res.bin   = p3_bin_r;
    res.st    = st;
    res.trans = trans;
    res.srun  = srun_n;
    res.arun  = arun_n;
    res.eff   = p3_eff_r;
    res.diff  = (p3_eff_zero_r || p3_last_zero_r) ? '0 : p3_diff_r;
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r)  mem[clr_idx_r] <= '0;
    else if (p3_v_r) mem[p3_idx_r]  <= new_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) wb_v_r <= 1'b0;
    else        wb_v_r <= p3_v_r;
  end

  always_ff @(posedge clk) begin
    wb_idx_r <= p3_idx_r;
    wb_ent_r <= new_ent;
  end

  // ---------------------------------------------------------------- result FIFO
  res_t            fifo [FD];
  logic [FA_W-1:0] f_wr_r, f_rd_r;
  logic [FC_W-1:0] f_cnt_r, f_cnt_nxt;
  res_t            head;

  always_comb begin
    f_cnt_nxt = f_cnt_r;
    if (p3_v_r && !out_acc) f_cnt_nxt = f_cnt_r + 1'b1;
    if (!p3_v_r && out_acc) f_cnt_nxt = f_cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_wr_r  <= '0;
      f_rd_r  <= '0;
      f_cnt_r <= '0;
    end else begin
      if (p3_v_r)  f_wr_r <= f_wr_r + 1'b1;
      if (out_acc) f_rd_r <= f_rd_r + 1'b1;
      f_cnt_r <= f_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (p3_v_r) fifo[f_wr_r] <= res;
  end

  assign head = fifo[f_rd_r];

  assign out_ch.valid               = (f_cnt_r != '0);
  assign out_ch.out_bin_index       = head.bin;
  assign out_ch.envelope_state      = head.st;
  assign out_ch.is_transition       = head.trans;
  assign out_ch.state_run_frames    = head.srun;
  assign out_ch.active_run_frames   = head.arun;
  assign out_ch.effective_amplitude = head.eff;
  assign out_ch.first_difference    = $signed(head.diff);

endmodule

FILE: hdl/sbest_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the envelope state tracker, bound to the top level.
module sbest_chk #(
  parameter int AMP_BITS   = 24,
  parameter int COUNT_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sbest_pkg::ST_W-1:0]    envelope_state,
  input logic                          is_transition,
  input logic [COUNT_BITS-1:0]         state_run_frames,
  input logic [COUNT_BITS-1:0]         active_run_frames,
  input logic [AMP_BITS-1:0]           effective_amplitude,
  input logic signed [AMP_BITS:0]      first_difference
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(envelope_state)
      && $stable(state_run_frames) && $stable(effective_amplitude))
    else $error("result changed while stalled");

  // null state clears run counters, transition flag, amplitude and difference
  a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && envelope_state == sbest_pkg::ST_NULL |->
      state_run_frames == '0 && active_run_frames == '0 && !is_transition
      && effective_amplitude == '0 && first_difference == '0)
    else $error("null result carries nonzero fields");

  // a transition starts a new state run
  a_trans_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_transition |-> state_run_frames == COUNT_BITS'(1)
      && active_run_frames != '0)
    else $error("transition without fresh state run");

  // active run never shorter than state run
  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && envelope_state != sbest_pkg::ST_NULL |->
      state_run_frames != '0 && active_run_frames >= state_run_frames)
    else $error("run counters out of order");

endmodule

bind spectral_bin_envelope_state_tracker sbest_chk #(
  .AMP_BITS   (AMP_BITS),
  .COUNT_BITS (COUNT_BITS)
) u_sbest_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .envelope_state      (out_ch.envelope_state),
  .is_transition       (out_ch.is_transition),
  .state_run_frames    (out_ch.state_run_frames),
  .active_run_frames   (out_ch.active_run_frames),
  .effective_amplitude (out_ch.effective_amplitude),
  .first_difference    (out_ch.first_difference)
);
